### src/abs_pkg.sv
// shared types, constants and helpers for the averaging background segmenter
// no dependencies; imported by every module under src
package abs_pkg;

  localparam int PIXELS_DEF     = 65536;
  localparam int MAX_FRAMES_DEF = 1024;

  localparam int IDX_W     = 16;
  localparam int PIX_W     = 8;
  localparam int CH_W      = 18;
  localparam int COUNT_W   = 11;
  localparam int COUNT_MAX = 2047;
  localparam int SCALE_W   = 10;
  localparam int CFG_IDX_W = 1;

  localparam logic [SCALE_W-1:0] HIGH_SCALE_RST = 10'd100;
  localparam logic [SCALE_W-1:0] LOW_SCALE_RST  = 10'd80;
  localparam logic [PIX_W-1:0]   FG_RED         = 8'd255;

  localparam logic FUNC_LEARN    = 1'b0;
  localparam logic FUNC_CLASSIFY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_HIGH_SCALE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_SCALE  = 1'd1;

  localparam int OQ_DEPTH = 8;
  localparam int OQ_AW    = 3;
  localparam int OQ_CW    = 4;

  typedef logic [2:0][PIX_W-1:0] bgr_t;
  typedef logic [2:0][CH_W-1:0]  chan_sums_t;

  typedef struct packed {
    logic             func;
    logic [IDX_W-1:0] pixel_index;
    logic             seed_frame;
    logic             end_of_frame;
    logic [PIX_W-1:0] blue;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] red;
  } in_word_t;

  typedef struct packed {
    logic [IDX_W-1:0] out_index;
    logic             foreground;
    logic [PIX_W-1:0] out_blue;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_red;
  } out_word_t;

  typedef struct packed {
    chan_sums_t csum;
    chan_sums_t dsum;
    bgr_t       prev;
  } entry_t;

  typedef struct packed {
    logic               valid;
    in_word_t           word;
    chan_sums_t         csum;
    chan_sums_t         dsum;
    logic [COUNT_W-1:0] n;
  } cls_req_t;

  function automatic int addr_w(input int p);
    return (p > 1) ? $clog2(p) : 1;
  endfunction

endpackage

### src/abs_index.sv
// pixel index reduction to a model slot, two stages (reciprocal multiply, then remainder)
// depends on abs_pkg
module abs_index import abs_pkg::*; #(
  parameter int PIXELS = PIXELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_acc,
  input  in_word_t                     in_word,
  output logic                         b_valid,
  output in_word_t                     b_word,
  output logic [addr_w(PIXELS)-1:0]    b_slot
);

  localparam int AW     = addr_w(PIXELS);
  localparam int K      = IDX_W + AW;
  localparam int RW     = IDX_W + 2;
  localparam int PW     = IDX_W + RW;
  localparam longint RECIP = (longint'(1) << K) / PIXELS;
  localparam int CW     = ((AW > IDX_W) ? AW : IDX_W) + 1;

  logic             a_valid_r;
  in_word_t         a_word_r;
  logic [IDX_W-1:0] a_q_r;
  logic             b_valid_r;
  in_word_t         b_word_r;
  logic [IDX_W-1:0] b_rem_r;

  logic [PW-1:0]    qprod;
  logic [IDX_W-1:0] q_nxt;
  logic [IDX_W-1:0] qp;
  logic [IDX_W-1:0] rem_nxt;
  logic [CW-1:0]    rem_c;
  logic [CW-1:0]    slot_c;

  // quotient may come out one low, fixed by the compare below
  assign qprod   = PW'(in_word.pixel_index) * PW'(RW'(RECIP));
  assign q_nxt   = IDX_W'(qprod >> K);
  assign qp      = IDX_W'(32'(a_q_r) * 32'(PIXELS));
  assign rem_nxt = a_word_r.pixel_index - qp;
  assign rem_c   = CW'(b_rem_r);
  assign slot_c  = (rem_c >= CW'(PIXELS)) ? rem_c - CW'(PIXELS) : rem_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_acc;
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    a_word_r <= in_word;
    a_q_r    <= q_nxt;
    b_word_r <= a_word_r;
    b_rem_r  <= rem_nxt;
  end

  assign b_valid = b_valid_r;
  assign b_word  = b_word_r;
  assign b_slot  = slot_c[AW-1:0];

endmodule

### src/abs_model.sv
// per-pixel model memory with read-modify-write, forwarding and the frame counter
// depends on abs_pkg
module abs_model import abs_pkg::*; #(
  parameter int PIXELS     = PIXELS_DEF,
  parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      b_valid,
  input  in_word_t                  b_word,
  input  logic [addr_w(PIXELS)-1:0] b_slot,
  output cls_req_t                  cls_req,
  output logic                      retire
);

  localparam int AW = addr_w(PIXELS);
  localparam logic [COUNT_W-1:0] N_LIMIT =
    COUNT_W'((MAX_FRAMES < COUNT_MAX) ? MAX_FRAMES : COUNT_MAX);

  entry_t             mem_r [PIXELS];
  entry_t             rd_data_r;
  logic               c_valid_r;
  in_word_t           c_word_r;
  logic [AW-1:0]      c_slot_r;
  logic               fwd_hit_r;
  entry_t             fwd_data_r;
  logic [COUNT_W-1:0] n_r;
  logic [COUNT_W-1:0] n_nxt;

  entry_t entry;
  entry_t wr_data;
  logic   wr_en;
  logic   fwd_hit_nxt;

  assign entry       = fwd_hit_r ? fwd_data_r : rd_data_r;
  assign wr_en       = c_valid_r && (c_word_r.func == FUNC_LEARN);
  assign fwd_hit_nxt = wr_en && (c_slot_r == b_slot);

  always_comb begin
    bgr_t             px;
    logic [PIX_W-1:0] d;
    logic [CH_W:0]    cs;
    logic [CH_W:0]    ds;
    px = {c_word_r.red, c_word_r.green, c_word_r.blue};
    wr_data.prev = px;
    for (int k = 0; k < 3; k++) begin
      d  = (px[k] >= entry.prev[k]) ? px[k] - entry.prev[k] : entry.prev[k] - px[k];
      cs = {1'b0, entry.csum[k]} + (CH_W+1)'(px[k]);
      ds = {1'b0, entry.dsum[k]} + (CH_W+1)'(d);
      wr_data.csum[k] = cs[CH_W] ? {CH_W{1'b1}} : cs[CH_W-1:0];
      wr_data.dsum[k] = ds[CH_W] ? {CH_W{1'b1}} : ds[CH_W-1:0];
    end
    // seed word stores the pixel and zeroes both sums
    if (c_word_r.seed_frame) begin
      wr_data.csum = '0;
      wr_data.dsum = '0;
    end
  end

  always_comb begin
    n_nxt = n_r;
    if (wr_en && !c_word_r.seed_frame && c_word_r.end_of_frame && (n_r < N_LIMIT)) begin
      n_nxt = n_r + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[c_slot_r] <= wr_data;
    end
    rd_data_r <= mem_r[b_slot];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
      n_r       <= '0;
    end else begin
      c_valid_r <= b_valid;
      n_r       <= n_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_word_r   <= b_word;
    c_slot_r   <= b_slot;
    fwd_hit_r  <= fwd_hit_nxt;
    fwd_data_r <= wr_data;
  end

  assign cls_req.valid = c_valid_r && (c_word_r.func == FUNC_CLASSIFY);
  assign cls_req.word  = c_word_r;
  assign cls_req.csum  = entry.csum;
  assign cls_req.dsum  = entry.dsum;
  assign cls_req.n     = n_r;
  assign retire        = wr_en;

endmodule

### src/abs_classify.sv
// band test per channel in two stages: products, then scaled bounds; compare feeds the queue
// depends on abs_pkg
module abs_classify import abs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cls_req_t           cls_req,
  input  logic [SCALE_W-1:0] high_scale,
  input  logic [SCALE_W-1:0] low_scale,
  output logic               push,
  output out_word_t          push_word
);

  localparam int DN_W   = CH_W + 1;
  localparam int CN_W   = PIX_W + COUNT_W;
  localparam int PROD_W = SCALE_W + DN_W;
  localparam int CMP_W  = PROD_W + 1;

  logic                       d_valid_r;
  in_word_t                   d_word_r;
  logic [2:0][CH_W-1:0]       d_s_r;
  logic [2:0][DN_W-1:0]       d_dn_r;
  logic [2:0][CN_W-1:0]       d_cn_r;
  logic                       e_valid_r;
  in_word_t                   e_word_r;
  logic [2:0][CH_W-1:0]       e_s_r;
  logic [2:0][CN_W-1:0]       e_cn_r;
  logic [2:0][PROD_W-1:0]     e_lo_r;
  logic [2:0][PROD_W-1:0]     e_hi_r;

  logic [2:0][DN_W-1:0]       dn_nxt;
  logic [2:0][CN_W-1:0]       cn_nxt;
  logic [2:0][PROD_W-1:0]     lo_nxt;
  logic [2:0][PROD_W-1:0]     hi_nxt;
  bgr_t                       px;
  logic                       fg;

  assign px = {cls_req.word.red, cls_req.word.green, cls_req.word.blue};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dn_nxt[k] = DN_W'(cls_req.dsum[k]) + DN_W'(cls_req.n);
      cn_nxt[k] = CN_W'(px[k]) * CN_W'(cls_req.n);
      lo_nxt[k] = PROD_W'(low_scale) * PROD_W'(d_dn_r[k]);
      hi_nxt[k] = PROD_W'(high_scale) * PROD_W'(d_dn_r[k]);
    end
  end

  always_comb begin
    logic [CMP_W-1:0] lower;
    logic [CMP_W-1:0] upper;
    fg = 1'b0;
    for (int k = 0; k < 3; k++) begin
      lower = CMP_W'(e_cn_r[k]) + CMP_W'(e_lo_r[k]);
      upper = CMP_W'(e_s_r[k]) + CMP_W'(e_hi_r[k]);
      if ((lower < CMP_W'(e_s_r[k])) || (CMP_W'(e_cn_r[k]) > upper)) begin
        fg = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
      e_valid_r <= 1'b0;
    end else begin
      d_valid_r <= cls_req.valid;
      e_valid_r <= d_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    d_word_r <= cls_req.word;
    d_s_r    <= cls_req.csum;
    d_dn_r   <= dn_nxt;
    d_cn_r   <= cn_nxt;
    e_word_r <= d_word_r;
    e_s_r    <= d_s_r;
    e_cn_r   <= d_cn_r;
    e_lo_r   <= lo_nxt;
    e_hi_r   <= hi_nxt;
  end

  assign push                 = e_valid_r;
  assign push_word.out_index  = e_word_r.pixel_index;
  assign push_word.foreground = fg;
  assign push_word.out_blue   = e_word_r.blue;
  assign push_word.out_green  = e_word_r.green;
  assign push_word.out_red    = fg ? FG_RED : e_word_r.red;

endmodule

### src/abs_outq.sv
// result queue with slot reservation so the pipeline never has to stop
// depends on abs_pkg
module abs_outq import abs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_acc,
  input  logic      retire,
  input  logic      push,
  input  out_word_t push_word,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  out_word_t        q_r [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr_r;
  logic [OQ_AW-1:0] rd_ptr_r;
  logic [OQ_CW-1:0] cnt_r;
  logic [OQ_CW-1:0] occ_r;
  logic [OQ_CW-1:0] cnt_nxt;
  logic [OQ_CW-1:0] occ_nxt;
  logic             pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (cnt_r != '0);
  assign out_word  = q_r[rd_ptr_r];
  // one reserved place per word in flight or queued
  assign in_stall  = (occ_r == OQ_CW'(OQ_DEPTH));
  assign cnt_nxt   = cnt_r + OQ_CW'(push) - OQ_CW'(pop);
  assign occ_nxt   = occ_r + OQ_CW'(in_acc) - OQ_CW'(retire) - OQ_CW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      occ_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + OQ_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + OQ_AW'(1);
      end
      cnt_r <= cnt_nxt;
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

### src/average_background_segmenter.sv
// top level of the averaging background segmenter: config registers and block wiring
// depends on abs_pkg, abs_index, abs_model, abs_classify, abs_outq
//
// channel  direction  handshake              word
// in_      input      in_valid / in_stall    in_word_t (learn or classify one pixel)
// out_     output     out_valid / out_stall  out_word_t (one per classify word)
// cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data (scale registers)
//
// one word per cycle while in_stall is low; results reach out_valid through the queue
// throughput is limited by in_stall; the model memory has separate read and write ports
// model memory has no clearing pass; reset clears frame count, scales, valids and queue
// in_stall rises while eight words sit in the pipeline and the result queue together
module average_background_segmenter import abs_pkg::*; #(
  parameter int PIXELS     = PIXELS_DEF,
  parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_word,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SCALE_W-1:0]   cfg_data
);

  localparam int AW = addr_w(PIXELS);

  logic [SCALE_W-1:0] high_scale_r;
  logic [SCALE_W-1:0] low_scale_r;

  logic          in_acc;
  logic          b_valid;
  in_word_t      b_word;
  logic [AW-1:0] b_slot;
  cls_req_t      cls_req;
  logic          retire;
  logic          push;
  out_word_t     push_word;

  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_scale_r <= HIGH_SCALE_RST;
      low_scale_r  <= LOW_SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HIGH_SCALE: high_scale_r <= cfg_data;
        REG_LOW_SCALE:  low_scale_r  <= cfg_data;
      endcase
    end
  end

  abs_index #(
    .PIXELS (PIXELS)
  ) u_index (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_acc  (in_acc),
    .in_word (in_word),
    .b_valid (b_valid),
    .b_word  (b_word),
    .b_slot  (b_slot)
  );

  abs_model #(
    .PIXELS     (PIXELS),
    .MAX_FRAMES (MAX_FRAMES)
  ) u_model (
    .clk     (clk),
    .rst_n   (rst_n),
    .b_valid (b_valid),
    .b_word  (b_word),
    .b_slot  (b_slot),
    .cls_req (cls_req),
    .retire  (retire)
  );

  abs_classify u_classify (
    .clk        (clk),
    .rst_n      (rst_n),
    .cls_req    (cls_req),
    .high_scale (high_scale_r),
    .low_scale  (low_scale_r),
    .push       (push),
    .push_word  (push_word)
  );

  abs_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_acc    (in_acc),
    .retire    (retire),
    .push      (push),
    .push_word (push_word),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

### bench/abs_checker.sv
// checker for the averaging background segmenter: keeps its own copy of the model
// memories, predicts every classified word and compares it; depends on abs_pkg
module abs_checker import abs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_word_t             in_word,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_word_t            out_word,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SCALE_W-1:0]   cfg_data,
  output int                   mismatches,
  output int                   waiting,
  output int                   classified,
  output int                   foreground_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  chan_sums_t         colour_mem [PIXELS_DEF];
  chan_sums_t         diff_mem   [PIXELS_DEF];
  bgr_t               prev_mem   [PIXELS_DEF];
  logic [COUNT_W-1:0] frame_count;
  logic [SCALE_W-1:0] high_scale;
  logic [SCALE_W-1:0] low_scale;
  out_word_t          classified_q [$];
  out_word_t          want;

  function automatic logic [CH_W-1:0] add_clamped(logic [CH_W-1:0] sum, logic [PIX_W-1:0] v);
    logic [CH_W:0] t;
    t = {1'b0, sum} + (CH_W+1)'(v);
    return t[CH_W] ? {CH_W{1'b1}} : t[CH_W-1:0];
  endfunction

  function automatic void learn_pixel(in_word_t w);
    bgr_t             px;
    bgr_t             old;
    logic [PIX_W-1:0] d;
    int               k;
    px = {w.red, w.green, w.blue};
    if (w.seed_frame) begin
      colour_mem[w.pixel_index] = '0;
      diff_mem[w.pixel_index]   = '0;
    end else begin
      old = prev_mem[w.pixel_index];
      for (k = 0; k < 3; k++) begin
        d = (px[k] >= old[k]) ? px[k] - old[k] : old[k] - px[k];
        colour_mem[w.pixel_index][k] = add_clamped(colour_mem[w.pixel_index][k], px[k]);
        diff_mem[w.pixel_index][k]   = add_clamped(diff_mem[w.pixel_index][k], d);
      end
      if (w.end_of_frame && frame_count < MAX_FRAMES_DEF && frame_count < COUNT_MAX)
        frame_count++;
    end
    prev_mem[w.pixel_index] = px;
  endfunction

  function automatic out_word_t classify_pixel(in_word_t w);
    bgr_t        px;
    chan_sums_t  s;
    chan_sums_t  d;
    logic [47:0] n;
    logic [47:0] cn;
    logic [47:0] s_k;
    logic [47:0] d_k;
    logic        fg;
    out_word_t   r;
    int          k;
    px = {w.red, w.green, w.blue};
    s  = colour_mem[w.pixel_index];
    d  = diff_mem[w.pixel_index];
    n  = 48'(frame_count);
    fg = 1'b0;
    for (k = 0; k < 3; k++) begin
      cn  = 48'(px[k]) * n;
      s_k = 48'(s[k]);
      d_k = 48'(d[k]);
      if (cn + 48'(low_scale) * (d_k + n) < s_k) fg = 1'b1;
      if (cn > s_k + 48'(high_scale) * (d_k + n)) fg = 1'b1;
    end
    r.out_index  = w.pixel_index;
    r.foreground = fg;
    r.out_blue   = w.blue;
    r.out_green  = w.green;
    r.out_red    = fg ? FG_RED : w.red;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      frame_count = '0;
      high_scale  = HIGH_SCALE_RST;
      low_scale   = LOW_SCALE_RST;
      classified_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_HIGH_SCALE) high_scale = cfg_data;
        else if (cfg_index == REG_LOW_SCALE) low_scale = cfg_data;
      end
      if (out_valid && !out_stall) begin
        classified++;
        if (out_word.foreground) foreground_seen++;
        if (classified_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word %0d: idx %h fg %b b %h g %h r %h", classified,
                     out_word.out_index, out_word.foreground, out_word.out_blue,
                     out_word.out_green, out_word.out_red);
        end else begin
          want = classified_q.pop_front();
          if (out_word.out_index !== want.out_index || out_word.foreground !== want.foreground ||
              out_word.out_blue !== want.out_blue || out_word.out_green !== want.out_green ||
              out_word.out_red !== want.out_red) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch on word %0d: expected idx %h fg %b b %h g %h r %h, %s",
                       classified, want.out_index, want.foreground, want.out_blue,
                       want.out_green, want.out_red,
                       $sformatf("got idx %h fg %b b %h g %h r %h", out_word.out_index,
                                 out_word.foreground, out_word.out_blue,
                                 out_word.out_green, out_word.out_red));
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (in_word.func == FUNC_CLASSIFY) classified_q.push_back(classify_pixel(in_word));
        else learn_pixel(in_word);
      end
    end
    waiting = classified_q.size();
  end

endmodule

### bench/tb_average_background_segmenter.sv
// testbench top for average_background_segmenter: drives pixel words, scale writes and
// result stalls, then gives the verdict; depends on abs_pkg, the segmenter RTL and abs_checker
module tb_average_background_segmenter import abs_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int               RANDOM_ITEMS = 480;
  localparam int               PHASES       = 8;
  localparam int               SAT_ITEMS    = 300;
  localparam int               QUIET_LIMIT  = 2000;
  localparam int               SETTLE_WAIT  = 10;
  localparam int               POOL_SIZE    = 8;
  localparam logic [SCALE_W-1:0] SCALE_MAX  = '1;
  localparam logic [IDX_W-1:0] IDX_LO       = '0;
  localparam logic [IDX_W-1:0] IDX_HI       = '1;
  localparam logic [IDX_W-1:0] IDX_MID      = 16'h5A5A;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_word_t             in_word   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b1;
  out_word_t            out_word;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_HIGH_SCALE;
  logic [SCALE_W-1:0]   cfg_data  = '0;
  int                   mismatches;
  int                   waiting;
  int                   classified;
  int                   foreground_seen;
  int                   words_sent;
  int                   learns_sent;
  int                   reg_writes;
  bit                   burst_in;
  bit                   burst_out;
  logic [IDX_W-1:0]     pool [POOL_SIZE];
  bgr_t                 last_px [logic [IDX_W-1:0]];

  average_background_segmenter i_dut (.*);
  abs_checker i_checker (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bgr_t rgb(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g, logic [PIX_W-1:0] b);
    return {r, g, b};
  endfunction

  function automatic in_word_t pixel_word(logic func, logic [IDX_W-1:0] idx, logic seed,
                                          logic eof, bgr_t px);
    in_word_t w;
    w.func         = func;
    w.pixel_index  = idx;
    w.seed_frame   = seed;
    w.end_of_frame = eof;
    w.blue         = px[0];
    w.green        = px[1];
    w.red          = px[2];
    return w;
  endfunction

  function automatic bgr_t near_px(bgr_t base);
    bgr_t px;
    int   v;
    int   k;
    for (k = 0; k < 3; k++) begin
      v = int'(base[k]) + int'($urandom_range(0, 12)) - 6;
      if (v < 0) v = 0;
      else if (v > 255) v = 255;
      px[k] = 8'(v);
    end
    return px;
  endfunction

  task automatic send_word(in_word_t w);
    int gap;
    gap = burst_in ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!(in_valid && !in_stall));
    words_sent++;
    if (w.func == FUNC_LEARN) begin
      learns_sent++;
      last_px[w.pixel_index] = {w.red, w.green, w.blue};
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (waiting != 0) @(negedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic set_scales(logic [SCALE_W-1:0] hi_val, logic [SCALE_W-1:0] lo_val);
    cfg_valid <= 1'b1;
    cfg_index <= REG_HIGH_SCALE;
    cfg_data  <= hi_val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_index <= REG_LOW_SCALE;
    cfg_data  <= lo_val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    reg_writes += 2;
  endtask

  task automatic learn_frame(bit seed);
    int   k;
    bgr_t px;
    for (k = 0; k < POOL_SIZE; k++) begin
      if (last_px.exists(pool[k]) && $urandom_range(0, 7) != 0) px = near_px(last_px[pool[k]]);
      else px = 24'($urandom);
      send_word(pixel_word(FUNC_LEARN, pool[k], seed, k == POOL_SIZE - 1, px));
    end
  endtask

  task automatic classify_some(int count, bit wild);
    int               k;
    logic [IDX_W-1:0] idx;
    bgr_t             px;
    for (k = 0; k < count; k++) begin
      idx = pool[$urandom_range(0, POOL_SIZE - 1)];
      if (!wild && $urandom_range(0, 3) != 0) px = near_px(last_px[idx]);
      else px = 24'($urandom);
      send_word(pixel_word(FUNC_CLASSIFY, idx, 1'($urandom), 1'($urandom), px));
    end
  endtask

  task automatic run_phase(int p, int quota);
    int               start;
    logic [IDX_W-1:0] idx;
    settle();
    case (p % 5)
      0: set_scales(10'($urandom), 10'($urandom));
      1: set_scales('0, '0);
      2: set_scales(SCALE_MAX, SCALE_MAX);
      3: set_scales(10'($urandom_range(0, 3)), 10'($urandom_range(0, 3)));
      default: begin
        if ($urandom_range(0, 1) != 0) set_scales('0, SCALE_MAX);
        else set_scales(SCALE_MAX, '0);
      end
    endcase
    burst_in  = $urandom_range(0, 3) == 0;
    burst_out = $urandom_range(0, 3) == 0;
    start = words_sent;
    if (p == 0) learn_frame(1'b1);
    while (words_sent - start < quota) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          learn_frame($urandom_range(0, 5) == 0);
          classify_some($urandom_range(2, 8), 1'b0);
        end
        6, 7: classify_some($urandom_range(1, 5), 1'b1);
        8: begin
          idx = pool[$urandom_range(0, POOL_SIZE - 1)];
          send_word(pixel_word(FUNC_LEARN, idx, 1'($urandom), 1'($urandom), 24'($urandom)));
        end
        default: begin
          idx = IDX_W'($urandom);
          send_word(pixel_word(FUNC_LEARN, idx, 1'b1, 1'($urandom), 24'($urandom)));
          send_word(pixel_word(FUNC_CLASSIFY, idx, 1'($urandom), 1'($urandom),
                               near_px(last_px[idx])));
        end
      endcase
    end
  endtask

  // long run on one pixel: frame count and both sums climb high
  task automatic saturate();
    int k;
    settle();
    set_scales(10'($urandom_range(0, 3)), 10'($urandom_range(0, 3)));
    burst_in  = $urandom_range(0, 1) == 0;
    burst_out = 1'b0;
    for (k = 0; k < SAT_ITEMS; k++)
      send_word(pixel_word(FUNC_LEARN, pool[0], 1'b0, 1'b1,
                           (k % 2 != 0) ? rgb(255, 255, 255) : rgb(0, 0, 0)));
    classify_some(12, 1'b0);
    classify_some(6, 1'b1);
  endtask

  initial begin : receiver
    int hold;
    @(posedge clk);
    forever begin
      hold = burst_out ? 0 : $urandom_range(0, 17);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("no word moved for %0d cycles, %0d results outstanding", QUIET_LIMIT, waiting);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int p;
    pool[0] = IDX_LO;
    pool[1] = IDX_HI;
    for (p = 2; p < POOL_SIZE; p++) pool[p] = IDX_W'($urandom);
    burst_in  = 1'b0;
    burst_out = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset scales, no frames learned yet
    send_word(pixel_word(FUNC_LEARN, IDX_LO, 1'b1, 1'b1, rgb(0, 0, 0)));
    send_word(pixel_word(FUNC_LEARN, IDX_HI, 1'b1, 1'b0, rgb(255, 255, 255)));
    send_word(pixel_word(FUNC_CLASSIFY, IDX_LO, 1'b1, 1'b1, rgb(0, 0, 0)));
    send_word(pixel_word(FUNC_CLASSIFY, IDX_HI, 1'b0, 1'b0, rgb(255, 255, 255)));
    send_word(pixel_word(FUNC_LEARN, IDX_LO, 1'b0, 1'b0, rgb(255, 255, 255)));
    send_word(pixel_word(FUNC_LEARN, IDX_HI, 1'b0, 1'b1, rgb(0, 0, 0)));
    send_word(pixel_word(FUNC_CLASSIFY, IDX_LO, 1'b0, 1'b1, rgb(255, 255, 255)));
    send_word(pixel_word(FUNC_CLASSIFY, IDX_LO, 1'b1, 1'b0, rgb(0, 0, 0)));
    send_word(pixel_word(FUNC_CLASSIFY, IDX_HI, 1'b0, 1'b0, rgb(128, 255, 0)));

    // zero scales: band collapses to the exact mean
    settle();
    set_scales('0, '0);
    send_word(pixel_word(FUNC_LEARN, IDX_LO, 1'b0, 1'b1, rgb(255, 255, 255)));
    send_word(pixel_word(FUNC_CLASSIFY, IDX_LO, 1'b0, 1'b0, rgb(255, 255, 255)));
    send_word(pixel_word(FUNC_CLASSIFY, IDX_LO, 1'b0, 1'b0, rgb(255, 255, 254)));
    send_word(pixel_word(FUNC_CLASSIFY, IDX_LO, 1'b0, 1'b0, rgb(0, 255, 255)));
    send_word(pixel_word(FUNC_CLASSIFY, IDX_HI, 1'b0, 1'b0, rgb(0, 0, 0)));
    send_word(pixel_word(FUNC_CLASSIFY, IDX_HI, 1'b0, 1'b0, rgb(0, 0, 1)));

    // widest band
    settle();
    set_scales(SCALE_MAX, SCALE_MAX);
    send_word(pixel_word(FUNC_CLASSIFY, IDX_LO, 1'b0, 1'b0, rgb(0, 0, 0)));
    send_word(pixel_word(FUNC_CLASSIFY, IDX_HI, 1'b0, 1'b0, rgb(255, 255, 255)));
    send_word(pixel_word(FUNC_LEARN, IDX_MID, 1'b1, 1'b0, rgb(8'h0F, 8'hA5, 8'h5A)));
    send_word(pixel_word(FUNC_CLASSIFY, IDX_MID, 1'b0, 1'b0, rgb(8'h0F, 8'hA5, 8'h5A)));

    for (p = 0; p < PHASES; p++) begin
      if (p == PHASES - 2) saturate();
      run_phase(p, RANDOM_ITEMS / PHASES);
    end

    settle();
    @(negedge clk);
    $display("sent %0d pixel words (%0d learn) across %0d scale register writes",
             words_sent, learns_sent, reg_writes);
    $display("checked %0d classified words, %0d foreground, %0d mismatches",
             classified, foreground_seen, mismatches);
    if (mismatches == 0 && waiting == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

### files.f
src/abs_pkg.sv
src/abs_index.sv
src/abs_model.sv
src/abs_classify.sv
src/abs_outq.sv
src/average_background_segmenter.sv
bench/abs_checker.sv
bench/tb_average_background_segmenter.sv
